>>> rtl/contiguous_page_run_splitter_assert.svh
// assertion macros for the contiguous page run splitter
// expects clk and rst_n in the scope where a macro is used
`ifndef CONTIGUOUS_PAGE_RUN_SPLITTER_ASSERT_SVH
`define CONTIGUOUS_PAGE_RUN_SPLITTER_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define CPRS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define CPRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cprs_pkg.sv
// shared types and constants of the contiguous page run splitter
// no dependencies
package cprs_pkg;

    localparam int FRAME_W    = 48;
    localparam int PAGE_IDX_W = 10;
    localparam int CNT_W      = 11;
    localparam int CHUNK_W    = 6;
    localparam int SET_W      = 10;

    // command queue between front and back
    localparam int QDEPTH  = 8;
    localparam int QPTR_W  = 3;
    localparam int QCNT_W  = 4;

    // one run flush or one error result
    typedef struct packed {
        logic [PAGE_IDX_W-1:0] start;
        logic [CNT_W-1:0]      length;
        logic                  is_last;
        logic                  err;
    } cmd_t;

    // up to two commands per accepted page, cmd_a goes first
    typedef struct packed {
        logic wr_a;
        logic wr_b;
        cmd_t cmd_a;
        cmd_t cmd_b;
    } push_t;

    typedef struct packed {
        logic [CNT_W-1:0] page_cnt;
        logic             overflow;
    } front_status_t;

endpackage

>>> rtl/cprs_if.sv
// valid/ready channel interfaces: pages in, chunks out
// depends on cprs_pkg
interface cprs_page_if
    import cprs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FRAME_W-1:0] page_frame;
    logic               last_page;

    modport source (output valid, output page_frame, output last_page, input ready);
    modport sink (input valid, input page_frame, input last_page, output ready);
endinterface

interface cprs_chunk_if
    import cprs_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [PAGE_IDX_W-1:0] start_page;
    logic [CHUNK_W-1:0]    page_count;
    logic [SET_W-1:0]      set_number;
    logic                  last_set;
    logic                  too_long;

    modport source (output valid, output start_page, output page_count,
                    output set_number, output last_set, output too_long, input ready);
    modport sink (input valid, input start_page, input page_count,
                  input set_number, input last_set, input too_long, output ready);
endinterface

>>> rtl/contiguous_page_run_splitter.sv
// top level of the contiguous page run splitter
// depends on cprs_pkg, cprs_if, cprs_front, cprs_queue, cprs_back and contiguous_page_run_splitter_assert.svh
//
// pages: one item per page of a buffer, page_frame is the frame
//   number, last_page marks the final page. consecutive frames form a run.
// chunks: one item per chunk of a run. page_count is the largest power of
//   two not above the pages left, capped at MAX_CHUNK_PAGES. last_set marks
//   the final chunk of the buffer. a page at index MAX_PAGES or beyond gives
//   an item with too_long set and page_count zero, as do all later pages up
//   to the last one.
// path: a run's flush goes through the command queue, its chunks through the output register.
// throughput: one page per cycle in, one chunk per cycle out while the receiver takes them; the back end
//   cutting one chunk a cycle sets the output rate, and the front stalls
//   only while the eight-entry command queue has fewer than two free slots.
// when the receiver stalls, the output register holds its item and the
//   queue absorbs flushes until fewer than two slots are free, then pages.ready drops.
// reset clears run tracking, the queue and the output valid at once; there
//   is no start-up sweep.
module contiguous_page_run_splitter
    import cprs_pkg::*;
#(
    parameter int MAX_PAGES       = 1024,
    parameter int MAX_CHUNK_PAGES = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    cprs_page_if.sink          pages,
    cprs_chunk_if.source       chunks
);

    push_t             push;
    front_status_t     status;
    logic              pop;
    logic              head_valid;
    cmd_t              head;
    logic [QCNT_W-1:0] q_count;

    cprs_front #(
        .MAX_PAGES (MAX_PAGES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pages.valid),
        .in_frame (pages.page_frame),
        .in_last  (pages.last_page),
        .q_count  (q_count),
        .in_ready (pages.ready),
        .push     (push),
        .status   (status)
    );

    cprs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .count      (q_count)
    );

    cprs_back #(
        .MAX_CHUNK_PAGES (MAX_CHUNK_PAGES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_ready  (chunks.ready),
        .out_valid  (chunks.valid),
        .out_start  (chunks.start_page),
        .out_count  (chunks.page_count),
        .out_set    (chunks.set_number),
        .out_last   (chunks.last_set),
        .out_err    (chunks.too_long)
    );

`include "contiguous_page_run_splitter_assert.svh"

    `CPRS_ASSERT_SAME(a_queue_bound, 1'b1, q_count <= QCNT_W'(QDEPTH), "command queue overrun")
    `CPRS_ASSERT_SAME(a_chunk_shape, chunks.valid && !chunks.too_long, $onehot(chunks.page_count) && (chunks.page_count <= CHUNK_W'(MAX_CHUNK_PAGES)), "chunk size not a capped power of two")
    `CPRS_ASSERT_NEXT(a_buffer_clear, pages.valid && pages.ready && pages.last_page, (status.page_cnt == '0) && !status.overflow, "run state not cleared after last page")

endmodule

>>> rtl/cprs_front.sv
// front end: accepts pages, tracks the current run, issues flush and error commands
// depends on cprs_pkg
module cprs_front
    import cprs_pkg::*;
#(
    parameter int MAX_PAGES = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [FRAME_W-1:0] in_frame,
    input  logic              in_last,
    input  logic [QCNT_W-1:0] q_count,
    output logic              in_ready,
    output push_t             push,
    output front_status_t     status
);

    logic [FRAME_W-1:0]    expected_reg, expected_next;
    logic [PAGE_IDX_W-1:0] run_start_reg, run_start_next;
    logic [CNT_W-1:0]      run_len_reg, run_len_next;
    logic [CNT_W-1:0]      page_cnt_reg, page_cnt_next;
    logic                  overflow_reg, overflow_next;

    logic accept;
    logic reject;
    logic cont;
    logic brk;

    // need room for two commands: a broken run plus the final run
    assign in_ready = (QCNT_W'(QDEPTH) - q_count) >= QCNT_W'(2);
    assign accept   = in_valid && in_ready;
    assign reject   = overflow_reg || (page_cnt_reg >= CNT_W'(MAX_PAGES));
    // a frame of all ones has no successor, expected wraps to zero
    assign cont     = (page_cnt_reg != '0) && (in_frame == expected_reg)
                      && (expected_reg != '0);
    assign brk      = (page_cnt_reg != '0) && !cont;

    always_comb
    begin
        expected_next  = expected_reg;
        run_start_next = run_start_reg;
        run_len_next   = run_len_reg;
        page_cnt_next  = page_cnt_reg;
        overflow_next  = overflow_reg;
        push           = '0;

        if (accept)
        begin
            if (reject)
            begin
                overflow_next       = 1'b1;
                run_len_next        = '0;
                push.wr_a           = 1'b1;
                push.cmd_a.err      = 1'b1;
                push.cmd_a.is_last  = in_last;
            end
            else
            begin
                if (brk)
                begin
                    push.wr_a          = 1'b1;
                    push.cmd_a.start   = run_start_reg;
                    push.cmd_a.length  = run_len_reg;
                end
                if (cont)
                begin
                    run_len_next  = run_len_reg + CNT_W'(1);
                    expected_next = expected_reg + FRAME_W'(1);
                end
                else
                begin
                    run_start_next = page_cnt_reg[PAGE_IDX_W-1:0];
                    run_len_next   = CNT_W'(1);
                    expected_next  = in_frame + FRAME_W'(1);
                end
                page_cnt_next = page_cnt_reg + CNT_W'(1);

                if (in_last)
                begin
                    if (brk)
                    begin
                        push.wr_b          = 1'b1;
                        push.cmd_b.start   = run_start_next;
                        push.cmd_b.length  = run_len_next;
                        push.cmd_b.is_last = 1'b1;
                    end
                    else
                    begin
                        push.wr_a          = 1'b1;
                        push.cmd_a.start   = run_start_next;
                        push.cmd_a.length  = run_len_next;
                        push.cmd_a.is_last = 1'b1;
                    end
                end
            end

            if (in_last)
            begin
                expected_next  = '0;
                run_start_next = '0;
                run_len_next   = '0;
                page_cnt_next  = '0;
                overflow_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg  <= '0;
            run_start_reg <= '0;
            run_len_reg   <= '0;
            page_cnt_reg  <= '0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            expected_reg  <= expected_next;
            run_start_reg <= run_start_next;
            run_len_reg   <= run_len_next;
            page_cnt_reg  <= page_cnt_next;
            overflow_reg  <= overflow_next;
        end
    end

    assign status.page_cnt = page_cnt_reg;
    assign status.overflow = overflow_reg;

endmodule

>>> rtl/cprs_queue.sv
// command queue between front and back, two writes and one pop per cycle
// depends on cprs_pkg
module cprs_queue
    import cprs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  push_t             push,
    input  logic              pop,
    output logic              head_valid,
    output cmd_t              head,
    output logic [QCNT_W-1:0] count
);

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wptr_next  = wptr_reg + QPTR_W'(push.wr_a) + QPTR_W'(push.wr_b);
        rptr_next  = rptr_reg + QPTR_W'(pop);
        count_next = count_reg + QCNT_W'(push.wr_a) + QCNT_W'(push.wr_b)
                     - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.wr_a)
            mem_reg[wptr_reg] <= push.cmd_a;
        if (push.wr_b)
            mem_reg[wptr_reg + QPTR_W'(1)] <= push.cmd_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rptr_reg];
    assign count      = count_reg;

endmodule

>>> rtl/cprs_back.sv
// back end: cuts the queued runs into power-of-two chunks, one per cycle while the receiver takes them
// depends on cprs_pkg
module cprs_back
    import cprs_pkg::*;
#(
    parameter int MAX_CHUNK_PAGES = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  cmd_t                  head,
    output logic                  pop,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [PAGE_IDX_W-1:0] out_start,
    output logic [CHUNK_W-1:0]    out_count,
    output logic [SET_W-1:0]      out_set,
    output logic                  out_last,
    output logic                  out_err
);

    // largest power of two not above left, capped at the chunk limit
    function automatic logic [CHUNK_W-1:0] chunk_of(input logic [CNT_W-1:0] left);
        logic [CNT_W-1:0] p;
        p = '0;
        for (int b = 0; b < CNT_W; b++)
        begin
            if (left[b])
                p = CNT_W'(1) << b;
        end
        if (p > CNT_W'(MAX_CHUNK_PAGES))
            p = CNT_W'(MAX_CHUNK_PAGES);
        return p[CHUNK_W-1:0];
    endfunction

    logic [CNT_W-1:0] done_reg, done_next;
    logic [SET_W-1:0] set_reg, set_next;
    logic             valid_reg, valid_next;

    logic [PAGE_IDX_W-1:0] start_reg;
    logic [CHUNK_W-1:0]    count_reg;
    logic [SET_W-1:0]      setnum_reg;
    logic                  last_reg;
    logic                  err_reg;

    logic [CNT_W-1:0]      left;
    logic [PAGE_IDX_W-1:0] idx;
    logic [CHUNK_W-1:0]    chunk;
    logic                  take;
    logic                  run_done;

    assign left     = head.length - done_reg;
    assign idx      = head.start + done_reg[PAGE_IDX_W-1:0];
    assign chunk    = chunk_of(left);
    assign take     = head_valid && (!valid_reg || out_ready);
    assign run_done = head.err || (CNT_W'(chunk) == left);
    assign pop      = take && run_done;

    always_comb
    begin
        done_next  = done_reg;
        set_next   = set_reg;
        valid_next = valid_reg && !out_ready;
        if (take)
        begin
            valid_next = 1'b1;
            done_next  = run_done ? '0 : done_reg + CNT_W'(chunk);
            if (head.is_last && run_done)
                set_next = '0;
            else if (!head.err)
                set_next = set_reg + SET_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= '0;
            set_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            done_reg  <= done_next;
            set_reg   <= set_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            setnum_reg <= set_reg;
            last_reg   <= head.is_last && run_done;
            err_reg    <= head.err;
            start_reg  <= head.err ? '0 : idx;
            count_reg  <= head.err ? '0 : chunk;
        end
    end

    assign out_valid = valid_reg;
    assign out_start = start_reg;
    assign out_count = count_reg;
    assign out_set   = setnum_reg;
    assign out_last  = last_reg;
    assign out_err   = err_reg;

endmodule

>>> tb/sv/tb_contiguous_page_run_splitter.sv
`timescale 1ns / 100ps
// self-checking testbench of contiguous_page_run_splitter: streams page frames, predicts the chunks
// depends on cprs_pkg, cprs_if and the rtl of contiguous_page_run_splitter
module tb_contiguous_page_run_splitter;
    import cprs_pkg::*;

    localparam int MAX_PAGES       = 1024;
    localparam int MAX_CHUNK_PAGES = 32;
    localparam int STALL_LIMIT     = 1000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RANDOM_PAGES    = 80;
    localparam int DIRECTED_ROWS   = 19;

    typedef struct packed {
        logic [PAGE_IDX_W-1:0] start_page;
        logic [CHUNK_W-1:0]    page_count;
        logic [SET_W-1:0]      set_number;
        logic                  last_set;
        logic                  too_long;
    } chunk_t;

    // pinned rows carry their one chunk typed in, the rest use the predictor
    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               last;
        logic               pinned;
        chunk_t             chunk;
    } page_row_t;

    localparam chunk_t NO_CHUNK = '0;

    logic clk = 1'b0;
    logic rst_n;
    bit   steady;
    bit   sender_calm;
    int   error_count;

    chunk_t chunks_due [$];
    chunk_t page_chunks [$];

    // predictor state
    logic [FRAME_W-1:0]    next_frame;
    logic [PAGE_IDX_W-1:0] run_first;
    logic [CNT_W-1:0]      run_len;
    logic [CNT_W-1:0]      pages_seen;
    logic [SET_W-1:0]      chunks_cut;
    bit                    rejecting;

    page_row_t directed_rows [DIRECTED_ROWS] = '{
        // single page buffers at both ends of the frame range
        '{48'h0000_0000_0000, 1'b1, 1'b1, '{10'd0, 6'd1, 10'd0, 1'b1, 1'b0}},
        '{48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, '{10'd0, 6'd1, 10'd0, 1'b1, 1'b0}},
        // all ones has no successor
        '{48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, NO_CHUNK},
        '{48'h0000_0000_0000, 1'b1, 1'b0, NO_CHUNK},
        '{48'h1234_5678_0000, 1'b0, 1'b0, NO_CHUNK},
        '{48'h1234_5678_0001, 1'b0, 1'b0, NO_CHUNK},
        '{48'h1234_5678_0002, 1'b0, 1'b0, NO_CHUNK},
        '{48'h1234_5678_0003, 1'b0, 1'b0, NO_CHUNK},
        '{48'h1234_5678_0004, 1'b1, 1'b0, NO_CHUNK},
        '{48'hAAAA_AAAA_AAAA, 1'b0, 1'b0, NO_CHUNK},
        '{48'h5555_5555_5555, 1'b1, 1'b0, NO_CHUNK},
        // repeated frame never continues a run
        '{48'h0000_0000_0003, 1'b0, 1'b0, NO_CHUNK},
        '{48'h0000_0000_0003, 1'b0, 1'b0, NO_CHUNK},
        '{48'h0000_0000_0003, 1'b1, 1'b0, NO_CHUNK},
        // carry through every bit still continues
        '{48'h7FFF_FFFF_FFFF, 1'b0, 1'b0, NO_CHUNK},
        '{48'h8000_0000_0000, 1'b1, 1'b1, '{10'd0, 6'd2, 10'd0, 1'b1, 1'b0}},
        '{48'hFFFF_FFFF_FFFE, 1'b0, 1'b0, NO_CHUNK},
        '{48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, NO_CHUNK},
        '{48'h0000_0000_0000, 1'b1, 1'b0, NO_CHUNK}
    };

    cprs_page_if  pages_bus ();
    cprs_chunk_if chunks_bus ();

    contiguous_page_run_splitter #(
        .MAX_PAGES       (MAX_PAGES),
        .MAX_CHUNK_PAGES (MAX_CHUNK_PAGES)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pages  (pages_bus),
        .chunks (chunks_bus)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int chunk_pages(input int left);
        int p;
        p = 1;
        while (p * 2 <= left)
            p = p * 2;
        return (p > MAX_CHUNK_PAGES) ? MAX_CHUNK_PAGES : p;
    endfunction

    task automatic clear_tracking();
        next_frame = '0;
        run_first  = '0;
        run_len    = '0;
        pages_seen = '0;
        chunks_cut = '0;
        rejecting  = 1'b0;
    endtask

    task automatic cut_run(input bit closing);
        int left;
        int c;
        logic [PAGE_IDX_W-1:0] idx;
        left = run_len;
        idx  = run_first;
        while (left != 0)
        begin
            c = chunk_pages(left);
            page_chunks.push_back('{idx, CHUNK_W'(c), chunks_cut, closing && (c == left), 1'b0});
            left -= c;
            idx = idx + PAGE_IDX_W'(c);
            chunks_cut = chunks_cut + 1'b1;
        end
        run_len = '0;
    endtask

    task automatic open_run(input logic [FRAME_W-1:0] frame);
        run_first  = pages_seen[PAGE_IDX_W-1:0];
        run_len    = CNT_W'(1);
        next_frame = frame + 1'b1;
    endtask

    // chunks caused by one page, left in page_chunks
    task automatic split_page(input logic [FRAME_W-1:0] frame, input logic last);
        page_chunks.delete();
        if (rejecting || pages_seen >= MAX_PAGES)
        begin
            rejecting = 1'b1;
            run_len   = '0;
            page_chunks.push_back('{'0, '0, chunks_cut, last, 1'b1});
            if (last)
                clear_tracking();
        end
        else
        begin
            if (pages_seen == 0)
                open_run(frame);
            else if (frame == next_frame && next_frame != 0)
            begin
                run_len    = run_len + 1'b1;
                next_frame = next_frame + 1'b1;
            end
            else
            begin
                cut_run(1'b0);
                open_run(frame);
            end
            pages_seen = pages_seen + 1'b1;
            if (last)
            begin
                cut_run(1'b1);
                clear_tracking();
            end
        end
    endtask

    task automatic send_page(input logic [FRAME_W-1:0] frame, input logic last,
                             input logic pinned, input chunk_t pinned_chunk);
        if (!steady && !sender_calm && $urandom_range(0, 4) == 0)
        begin
            pages_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        pages_bus.valid      <= 1'b1;
        pages_bus.page_frame <= frame;
        pages_bus.last_page  <= last;
        do
            @(posedge clk);
        while (!pages_bus.ready);
        split_page(frame, last);
        if (pinned)
            chunks_due.push_back(pinned_chunk);
        else
            foreach (page_chunks[k])
                chunks_due.push_back(page_chunks[k]);
    endtask

    function automatic logic [FRAME_W-1:0] any_frame();
        logic [63:0] bits;
        bits = {$urandom(), $urandom()};
        return bits[FRAME_W-1:0];
    endfunction

    // bias run bases toward the wrap point and toward zero
    function automatic logic [FRAME_W-1:0] pick_frame();
        unique case ($urandom_range(0, 5))
            0: return {FRAME_W{1'b1}} - FRAME_W'($urandom_range(0, 40));
            1: return FRAME_W'($urandom_range(0, 100));
            default: return any_frame();
        endcase
    endfunction

    function automatic int pick_run();
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(33, 70);
        return $urandom_range(1, 20);
    endfunction

    // one buffer of runs; first_run forces the length of the opening run
    task automatic send_buffer(input int n_pages, input int first_run, input bit noisy);
        logic [FRAME_W-1:0] frame;
        int run_left;
        sender_calm = ($urandom_range(0, 3) == 0);
        frame = pick_frame();
        run_left = (first_run != 0) ? first_run : pick_run();
        for (int i = 0; i < n_pages; i++)
        begin
            if (run_left == 0)
            begin
                frame = pick_frame();
                run_left = pick_run();
            end
            if (noisy && $urandom_range(0, 7) == 0)
                send_page(any_frame(), i == n_pages - 1, 1'b0, NO_CHUNK);
            else
                send_page(frame, i == n_pages - 1, 1'b0, NO_CHUNK);
            frame = frame + 1'b1;
            run_left--;
        end
    endtask

    task automatic wait_drained();
        pages_bus.valid <= 1'b0;
        while (chunks_due.size() != 0)
            @(posedge clk);
    endtask

    // receiver: stall bursts inside busy stretches, calm stretches in between
    initial
    begin : chunk_drain
        int hold;
        int stretch;
        bit calm;
        stretch = 0;
        calm = 1'b0;
        chunks_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stretch == 0)
            begin
                calm = ($urandom_range(0, 2) == 0);
                stretch = $urandom_range(20, 80);
            end
            stretch--;
            if (!steady && !calm && $urandom_range(0, 3) == 0)
            begin
                hold = $urandom_range(1, 7);
                chunks_bus.ready <= 1'b0;
                repeat (hold - 1) @(posedge clk);
            end
            else
                chunks_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : chunk_check
        chunk_t want;
        if (rst_n && chunks_bus.valid && chunks_bus.ready)
        begin
            if (chunks_due.size() == 0)
            begin
                $error("unexpected chunk: start_page %0d page_count %0d set_number %0d",
                       chunks_bus.start_page, chunks_bus.page_count, chunks_bus.set_number);
                error_count++;
            end
            else
            begin
                want = chunks_due.pop_front();
                if (chunks_bus.start_page !== want.start_page)
                begin
                    $error("start_page: expected %0d, got %0d",
                           want.start_page, chunks_bus.start_page);
                    error_count++;
                end
                if (chunks_bus.page_count !== want.page_count)
                begin
                    $error("page_count: expected %0d, got %0d",
                           want.page_count, chunks_bus.page_count);
                    error_count++;
                end
                if (chunks_bus.set_number !== want.set_number)
                begin
                    $error("set_number: expected %0d, got %0d",
                           want.set_number, chunks_bus.set_number);
                    error_count++;
                end
                if (chunks_bus.last_set !== want.last_set)
                begin
                    $error("last_set: expected %0d, got %0d",
                           want.last_set, chunks_bus.last_set);
                    error_count++;
                end
                if (chunks_bus.too_long !== want.too_long)
                begin
                    $error("too_long: expected %0d, got %0d",
                           want.too_long, chunks_bus.too_long);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((pages_bus.valid && pages_bus.ready) || (chunks_bus.valid && chunks_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        int random_pages;
        int n;
        error_count = 0;
        random_pages = 0;
        steady = 1'b0;
        sender_calm = 1'b0;
        clear_tracking();
        rst_n <= 1'b0;
        pages_bus.valid      <= 1'b0;
        pages_bus.page_frame <= '0;
        pages_bus.last_page  <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            send_page(directed_rows[r].frame, directed_rows[r].last,
                      directed_rows[r].pinned, directed_rows[r].chunk);
        // hold pages back until every chunk is out
        wait_drained();

        while (random_pages < RANDOM_PAGES)
        begin
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
            send_buffer(n, 0, $urandom_range(0, 3) == 0);
            random_pages += n;
        end

        // full rate: a long run broken on the last page, then two short buffers
        steady = 1'b1;
        send_buffer(40, 39, 1'b0);
        repeat (2) send_buffer($urandom_range(1, 10), 0, 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (chunks_due.size() != 0)
        begin
            $error("%0d chunks never arrived", chunks_due.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/cprs_pkg.sv
rtl/cprs_if.sv
rtl/cprs_front.sv
rtl/cprs_queue.sv
rtl/cprs_back.sv
rtl/contiguous_page_run_splitter.sv
tb/sv/tb_contiguous_page_run_splitter.sv
